// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/cru_pkg.sv =====
// ---------------------------------------------------------------------------
// cru_pkg
// Shared constants for the contact run cleanup block.
// ---------------------------------------------------------------------------
package cru_pkg;
   localparam int MAX_FRAMES = 1024;
   localparam int ADDR_W     = $clog2(MAX_FRAMES);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int WORD_BITS  = 64;
   localparam int WIDX_W     = ADDR_W - $clog2(WORD_BITS);
   localparam int POS_W      = 48;
endpackage

// ===== rtl/core/cru_ram.sv =====
// ---------------------------------------------------------------------------
// cru_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module cru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/contact_run_cleanup.sv =====
// ---------------------------------------------------------------------------
// contact_run_cleanup
// Foot contact marking with run cleanup passes and 64-bit mark readout.
// ---------------------------------------------------------------------------
// A load beat without last leaves busy low. A load beat with last starts the
// cleanup passes over n frames: each pass walks the mark RAM frame by frame,
// closing each run or gap that it meets, rewriting frames and, in the position
// pass, running distance checks, all through one mark RAM port and one shared
// squarer; word 0 is then read out as for a read beat. A read beat holds busy
// for one mark RAM read per bit plus the registered read. Each result is shown
// for one cycle on rsp_valid, in the cycle busy drops, and cannot be held off;
// the next beat may be accepted in that same cycle.
module contact_run_cleanup (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic signed [15:0]          req_pos_x,
   input  logic signed [15:0]          req_pos_y,
   input  logic signed [15:0]          req_pos_z,
   input  logic [15:0]                 req_speed,
   input  logic                        req_last,
   input  logic [cru_pkg::WIDX_W-1:0]  req_word_index,
   output logic                        rsp_valid,
   output logic [63:0]                 rsp_mark_word,
   output logic [cru_pkg::WIDX_W-1:0]  rsp_word_echo,
   output logic                        rsp_done_res,
   output logic [cru_pkg::CNT_W-1:0]   rsp_frame_total,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [5:0]                  paddr,
   input  logic [63:0]                 pwdata,
   output logic [63:0]                 prdata,
   output logic                        pready
);
   import cru_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_RD   = 11'b000_0000_0010,
      S_CHK  = 11'b000_0000_0100,
      S_DEC  = 11'b000_0000_1000,
      S_WR   = 11'b000_0001_0000,
      S_PA   = 11'b000_0010_0000,
      S_PB   = 11'b000_0100_0000,
      S_PC   = 11'b000_1000_0000,
      S_MUL  = 11'b001_0000_0000,
      S_CMP  = 11'b010_0000_0000,
      S_RO   = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      P_CLEAR = 2'd0,
      P_TRIM  = 2'd1,
      P_FILL  = 2'd2,
      P_POS   = 2'd3
   } pass_type;

   localparam logic [2:0] R_HEIGHT = 3'd0;
   localparam logic [2:0] R_SPEED  = 3'd1;
   localparam logic [2:0] R_MINRUN = 3'd2;
   localparam logic [2:0] R_TRIM   = 3'd3;
   localparam logic [2:0] R_FILL   = 3'd4;
   localparam logic [2:0] R_SGAP   = 3'd5;
   localparam logic [2:0] R_PGAP   = 3'd6;
   localparam logic [2:0] R_DIST   = 3'd7;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);
   localparam int RO_W = $clog2(WORD_BITS) + 1;
   localparam logic [RO_W-1:0] RO_LAST = RO_W'(WORD_BITS);

   // configuration
   logic signed [15:0] cfg_height_ff;
   logic [15:0]        cfg_speed_ff;
   logic [10:0]        cfg_minrun_ff;
   logic [9:0]         cfg_trim_ff;
   logic               cfg_fill_ff;
   logic [10:0]        cfg_sgap_ff;
   logic [10:0]        cfg_pgap_ff;
   logic [33:0]        cfg_dist_ff;
   logic               cfg_we;
   logic [2:0]         cfg_idx;

   assign pready  = 1'b1;
   assign cfg_idx = paddr[5:3];
   assign cfg_we  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_height_ff <= '0;
         cfg_speed_ff  <= '0;
         cfg_minrun_ff <= 11'd1;
         cfg_trim_ff   <= '0;
         cfg_fill_ff   <= 1'b0;
         cfg_sgap_ff   <= '0;
         cfg_pgap_ff   <= '0;
         cfg_dist_ff   <= '0;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            R_HEIGHT: cfg_height_ff <= pwdata[15:0];
            R_SPEED:  cfg_speed_ff  <= pwdata[15:0];
            R_MINRUN: cfg_minrun_ff <= pwdata[10:0];
            R_TRIM:   cfg_trim_ff   <= pwdata[9:0];
            R_FILL:   cfg_fill_ff   <= pwdata[0];
            R_SGAP:   cfg_sgap_ff   <= pwdata[10:0];
            R_PGAP:   cfg_pgap_ff   <= pwdata[10:0];
            R_DIST:   cfg_dist_ff   <= pwdata[33:0];
            default:  cfg_dist_ff   <= cfg_dist_ff;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         R_HEIGHT: prdata = {48'd0, cfg_height_ff};
         R_SPEED:  prdata = {48'd0, cfg_speed_ff};
         R_MINRUN: prdata = {53'd0, cfg_minrun_ff};
         R_TRIM:   prdata = {54'd0, cfg_trim_ff};
         R_FILL:   prdata = {63'd0, cfg_fill_ff};
         R_SGAP:   prdata = {53'd0, cfg_sgap_ff};
         R_PGAP:   prdata = {53'd0, cfg_pgap_ff};
         R_DIST:   prdata = {30'd0, cfg_dist_ff};
         default:  prdata = '0;
      endcase
   end

   // control and datapath registers
   state_type          state_ff, state_in;
   pass_type           pass_ff, pass_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   seg_ff, seg_in;
   logic               inseg_ff, inseg_in;
   logic [CNT_W-1:0]   wk_ff, wk_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               done_ff, done_in;
   logic [2:0]         mc_ff, mc_in;
   logic signed [16:0] diff_ff, diff_in;
   logic [31:0]        prod_ff, prod_in;
   logic [33:0]        acc_ff, acc_in;
   logic [POS_W-1:0]   posa_ff, posa_in;
   logic [POS_W-1:0]   posb_ff, posb_in;
   logic [RO_W-1:0]    rok_ff, rok_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic [63:0]        word_ff, word_in;
   logic               rspv_ff, rspv_in;

   // memories
   logic               bit_we, bit_wd, bit_rd;
   logic [ADDR_W-1:0]  bit_wa, bit_ra;
   logic               pos_we;
   logic [ADDR_W-1:0]  pos_ra;
   logic [POS_W-1:0]   pos_rd;

   // load path
   logic               accept, load, fits, contact, wr_val;
   logic [CNT_W-1:0]   load_addr;

   assign accept    = start && (state_ff == S_IDLE);
   assign load      = accept && !req_cmd;
   assign load_addr = done_ff ? '0 : count_ff;
   assign fits      = load_addr < MAX_CNT;
   assign contact   = (req_pos_y < cfg_height_ff) && (req_speed < cfg_speed_ff);

   assign bit_we = (load && fits) || (state_ff == S_WR);
   assign bit_wa = (state_ff == S_WR) ? wk_ff[ADDR_W-1:0] : load_addr[ADDR_W-1:0];
   assign bit_wd = (state_ff == S_WR) ? wr_val : contact;
   assign bit_ra = (state_ff == S_RO) ? {widx_ff, rok_ff[RO_W-2:0]} : idx_ff[ADDR_W-1:0];

   assign pos_we = load && fits;
   assign pos_ra = (state_ff == S_PA) ? ADDR_W'(seg_ff - 1'b1) : idx_ff[ADDR_W-1:0];

   cru_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_mark_ram (
      .clock   (clock),
      .wr_en   (bit_we),
      .wr_addr (bit_wa),
      .wr_data (bit_wd),
      .rd_addr (bit_ra),
      .rd_data (bit_rd)
   );

   cru_ram #(.WIDTH(POS_W), .DEPTH(MAX_FRAMES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (load_addr[ADDR_W-1:0]),
      .wr_data ({req_pos_x, req_pos_y, req_pos_z}),
      .rd_addr (pos_ra),
      .rd_data (pos_rd)
   );

   // segment arithmetic
   logic [CNT_W-1:0] seg_len;
   logic [CNT_W:0]   s12, j12, k12, t12, mid12;
   logic             short_run, tgt, seg_bit;
   logic [15:0]      comp_a, comp_b;
   logic [ADDR_W-1:0] ro_f;
   logic [RO_W-1:0]  rok_m1;

   assign seg_len   = idx_ff - seg_ff;
   assign s12       = {1'b0, seg_ff};
   assign j12       = {1'b0, idx_ff};
   assign k12       = {1'b0, wk_ff};
   assign t12       = {2'b00, cfg_trim_ff};
   assign mid12     = (s12 + j12) >> 1;
   assign short_run = {1'b0, seg_len} <= {1'b0, cfg_trim_ff, 1'b0};
   assign tgt       = (pass_ff == P_CLEAR) || (pass_ff == P_TRIM);
   assign seg_bit   = (bit_rd == tgt);
   assign rok_m1    = rok_ff - 1'b1;
   assign ro_f      = {widx_ff, rok_m1[RO_W-2:0]};

   always_comb begin
      unique case (pass_ff)
         P_CLEAR: wr_val = 1'b0;
         P_TRIM:  wr_val = short_run ? (k12 == mid12)
                                     : ((k12 >= s12 + t12) && (k12 + t12 < j12));
         default: wr_val = 1'b1;
      endcase
   end

   always_comb begin
      unique case (mc_ff)
         3'd0:    begin comp_a = posa_ff[47:32]; comp_b = posb_ff[47:32]; end
         3'd1:    begin comp_a = posa_ff[31:16]; comp_b = posb_ff[31:16]; end
         default: begin comp_a = posa_ff[15:0];  comp_b = posb_ff[15:0];  end
      endcase
   end

   // sequencer
   always_comb begin
      logic             end_pass;
      logic signed [33:0] sq;
      state_in = state_ff;
      pass_in  = pass_ff;
      idx_in   = idx_ff;
      seg_in   = seg_ff;
      inseg_in = inseg_ff;
      wk_in    = wk_ff;
      count_in = count_ff;
      done_in  = done_ff;
      mc_in    = mc_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      posa_in  = posa_ff;
      posb_in  = posb_ff;
      rok_in   = rok_ff;
      widx_in  = widx_ff;
      word_in  = word_ff;
      rspv_in  = 1'b0;
      end_pass = 1'b0;
      sq       = diff_ff * diff_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd) begin
               widx_in  = req_word_index;
               rok_in   = '0;
               state_in = S_RO;
            end else if (load) begin
               count_in = load_addr + CNT_W'(fits);
               done_in  = 1'b0;
               if (req_last) begin
                  pass_in  = P_CLEAR;
                  idx_in   = '0;
                  inseg_in = 1'b0;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff == count_ff) begin
               if (inseg_ff) begin
                  state_in = S_DEC;
               end else begin
                  end_pass = 1'b1;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = S_RD;
            if (!inseg_ff) begin
               if (seg_bit) begin
                  inseg_in = 1'b1;
                  seg_in   = idx_ff;
               end
               idx_in = idx_ff + 1'b1;
            end else if (seg_bit) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            inseg_in = 1'b0;
            wk_in    = seg_ff;
            state_in = S_RD;
            unique case (pass_ff)
               P_CLEAR: if (seg_len < cfg_minrun_ff) state_in = S_WR;
               P_TRIM:  state_in = S_WR;
               P_FILL: begin
                  if (idx_ff == count_ff) end_pass = 1'b1;
                  else if (seg_len < cfg_sgap_ff) state_in = S_WR;
               end
               default: begin
                  if (idx_ff == count_ff) end_pass = 1'b1;
                  else if (seg_len < cfg_pgap_ff) state_in = S_PA;
               end
            endcase
         end
         S_WR: begin
            wk_in = wk_ff + 1'b1;
            if (wk_in == idx_ff) state_in = S_RD;
         end
         S_PA: state_in = S_PB;
         S_PB: begin
            posa_in  = pos_rd;
            state_in = S_PC;
         end
         S_PC: begin
            posb_in  = pos_rd;
            mc_in    = '0;
            acc_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mc_ff < 3'd3) begin
               diff_in = $signed({comp_a[15], comp_a}) - $signed({comp_b[15], comp_b});
            end
            if (mc_ff >= 3'd1 && mc_ff <= 3'd3) prod_in = sq[31:0];
            if (mc_ff >= 3'd2) acc_in = acc_ff + {2'b00, prod_ff};
            mc_in = mc_ff + 1'b1;
            if (mc_ff == 3'd4) state_in = S_CMP;
         end
         S_CMP: state_in = (acc_ff < cfg_dist_ff) ? S_WR : S_RD;
         S_RO: begin
            if (rok_ff != '0) begin
               word_in = {bit_rd && ({1'b0, ro_f} < count_ff), word_ff[63:1]};
            end
            if (rok_ff == RO_LAST) begin
               rspv_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               rok_in = rok_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (end_pass) begin
         inseg_in = 1'b0;
         idx_in   = '0;
         priority if (pass_ff == P_CLEAR && cfg_trim_ff != '0) begin
            pass_in  = P_TRIM;
            state_in = S_RD;
         end else if ((pass_ff == P_CLEAR || pass_ff == P_TRIM) && cfg_fill_ff) begin
            pass_in  = P_FILL;
            state_in = S_RD;
         end else if (pass_ff == P_FILL) begin
            pass_in  = P_POS;
            idx_in   = CNT_W'(1);
            state_in = S_RD;
         end else begin
            done_in  = 1'b1;
            widx_in  = '0;
            rok_in   = '0;
            state_in = S_RO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= P_CLEAR;
         inseg_ff <= 1'b0;
         count_ff <= '0;
         done_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
         mc_ff    <= '0;
         rok_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         inseg_ff <= inseg_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         rspv_ff  <= rspv_in;
         mc_ff    <= mc_in;
         rok_ff   <= rok_in;
      end
      idx_ff  <= idx_in;
      seg_ff  <= seg_in;
      wk_ff   <= wk_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      posa_ff <= posa_in;
      posb_ff <= posb_in;
      widx_ff <= widx_in;
      word_ff <= word_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rspv_ff;
   assign rsp_mark_word   = word_ff;
   assign rsp_word_echo   = widx_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_frame_total = count_ff;
endmodule

// ===== rtl/core/cru_checker.sv =====
// ---------------------------------------------------------------------------
// cru_checker
// Port-level checks for contact_run_cleanup, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cru_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_cmd,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic [cru_pkg::CNT_W-1:0]  rsp_frame_total
);
   import cru_pkg::*;

   logic rd_beat, last_beat;
   assign rd_beat   = start && !busy && req_cmd;
   assign last_beat = start && !busy && !req_cmd && req_last;

   `ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NXT(a_rd_busy, clock, reset, rd_beat, busy && !rsp_valid)
   `ASSERT_NXT(a_last_busy, clock, reset, last_beat, busy)
   `ASSERT_IMP(a_total_max, clock, reset, rsp_valid, rsp_frame_total <= CNT_W'(MAX_FRAMES))
endmodule

bind contact_run_cleanup cru_checker u_cru_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_cmd         (req_cmd),
   .req_last        (req_last),
   .rsp_valid       (rsp_valid),
   .rsp_frame_total (rsp_frame_total)
);

// ===== test/contact_run_cleanup_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contact_run_cleanup_check
// Watches the command, result and register ports of the contact run cleanup
// block. It keeps its own copy of frames, marks and registers, recomputes the
// run cleanup passes on the last frame and compares every result beat,
// field by field, against the oldest expected beat.
// ----------------------------------------------------------------------------
package cru_tb_pkg;
   typedef enum int {
      REG_HEIGHT_LIM = 0,
      REG_SPEED_LIM  = 1,
      REG_MIN_RUN    = 2,
      REG_TRIM       = 3,
      REG_FILL_EN    = 4,
      REG_SHORT_GAP  = 5,
      REG_POS_GAP    = 6,
      REG_GAP_DIST   = 7
   } csr_reg_type;

   typedef enum bit {
      CMD_LOAD = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;
endpackage

module contact_run_cleanup_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_cmd,
   input  logic signed [15:0]         req_pos_x,
   input  logic signed [15:0]         req_pos_y,
   input  logic signed [15:0]         req_pos_z,
   input  logic [15:0]                req_speed,
   input  logic                       req_last,
   input  logic [cru_pkg::WIDX_W-1:0] req_word_index,
   input  logic                       rsp_valid,
   input  logic [63:0]                rsp_mark_word,
   input  logic [cru_pkg::WIDX_W-1:0] rsp_word_echo,
   input  logic                       rsp_done_res,
   input  logic [cru_pkg::CNT_W-1:0]  rsp_frame_total,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [5:0]                 paddr,
   input  logic [63:0]                pwdata,
   output int                         mismatches,
   output int                         pending
);
   import cru_tb_pkg::*;

   localparam int NF = cru_pkg::MAX_FRAMES;

   typedef struct {
      logic [63:0]                mark_word;
      logic [cru_pkg::WIDX_W-1:0] word_echo;
      logic                       done_res;
      logic [cru_pkg::CNT_W-1:0]  frame_total;
   } mark_beat_type;

   mark_beat_type marks_due[$];

   logic signed [15:0] fx [NF];
   logic signed [15:0] fy [NF];
   logic signed [15:0] fz [NF];
   bit                 mark [NF];
   bit                 snap [NF];
   int                 frames  = 0;
   bit                 cleaned = 0;

   logic signed [15:0] lim_height = '0;
   logic [15:0]        lim_speed  = '0;
   int                 min_run    = 1;
   int                 trim_len   = 0;
   bit                 fill_en    = 0;
   int                 short_gap  = 0;
   int                 pos_gap    = 0;
   logic [33:0]        dist_limit = '0;

   initial mismatches = 0;

   function automatic void drop_short_runs();
      int i, j, k;
      i = 0;
      while (i < frames) begin
         if (!mark[i]) begin
            i++;
            continue;
         end
         j = i;
         while (j < frames && mark[j]) j++;
         if (j - i < min_run)
            for (k = i; k < j; k++) mark[k] = 0;
         i = j;
      end
   endfunction

   function automatic void trim_runs();
      int i, j, k;
      i = 0;
      if (trim_len == 0) return;
      while (i < frames) begin
         if (!mark[i]) begin
            i++;
            continue;
         end
         j = i;
         while (j < frames && mark[j]) j++;
         if (j - i <= 2 * trim_len) begin
            for (k = i; k < j; k++) mark[k] = 0;
            mark[(i + j) / 2] = 1;
         end else begin
            for (k = i; k < i + trim_len; k++) mark[k] = 0;
            for (k = j - trim_len; k < j; k++) mark[k] = 0;
         end
         i = j;
      end
   endfunction

   function automatic bit near(int a, int b);
      longint dx, dy, dz;
      longint unsigned d;
      dx = longint'(fx[a]) - longint'(fx[b]);
      dy = longint'(fy[a]) - longint'(fy[b]);
      dz = longint'(fz[a]) - longint'(fz[b]);
      d  = dx * dx + dy * dy + dz * dz;
      return d < longint'(dist_limit);
   endfunction

   function automatic void fill_gaps(int limit, bit by_pos);
      int i, j, k;
      i = by_pos ? 1 : 0;
      snap = mark;
      while (i < frames) begin
         if (snap[i]) begin
            i++;
            continue;
         end
         j = i;
         while (j < frames && !snap[j]) j++;
         if (j >= frames) break;
         if (j - i < limit && (!by_pos || near(i - 1, j)))
            for (k = i; k < j; k++) mark[k] = 1;
         i = j;
      end
   endfunction

   function automatic logic [63:0] mark_word_at(int w);
      logic [63:0] word;
      int k;
      word = '0;
      for (k = 0; k < 64; k++)
         if (w * 64 + k < frames && mark[w * 64 + k]) word[k] = 1'b1;
      return word;
   endfunction

   function automatic void predict_beat();
      mark_beat_type b;
      bit contact;
      if (req_cmd == CMD_READ) begin
         b.mark_word   = mark_word_at(req_word_index);
         b.word_echo   = req_word_index;
         b.done_res    = cleaned;
         b.frame_total = frames;
         marks_due.push_back(b);
         return;
      end
      if (cleaned) begin
         frames  = 0;
         cleaned = 0;
      end
      if (frames < NF) begin
         contact = (req_pos_y < lim_height) && (req_speed < lim_speed);
         fx[frames]   = req_pos_x;
         fy[frames]   = req_pos_y;
         fz[frames]   = req_pos_z;
         mark[frames] = contact;
         frames++;
      end
      if (!req_last) return;
      drop_short_runs();
      trim_runs();
      if (fill_en) begin
         fill_gaps(short_gap, 1'b0);
         fill_gaps(pos_gap, 1'b1);
      end
      cleaned = 1;
      b.mark_word   = mark_word_at(0);
      b.word_echo   = '0;
      b.done_res    = 1'b1;
      b.frame_total = frames;
      marks_due.push_back(b);
   endfunction

   function automatic void csr_update(int idx, logic [63:0] v);
      case (idx)
         REG_HEIGHT_LIM: lim_height = v[15:0];
         REG_SPEED_LIM:  lim_speed  = v[15:0];
         REG_MIN_RUN:    min_run    = v[10:0];
         REG_TRIM:       trim_len   = v[9:0];
         REG_FILL_EN:    fill_en    = v[0];
         REG_SHORT_GAP:  short_gap  = v[10:0];
         REG_POS_GAP:    pos_gap    = v[10:0];
         REG_GAP_DIST:   dist_limit = v[33:0];
         default: ;
      endcase
   endfunction

   function automatic void fail_beat(string what, mark_beat_type e);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s): exp mark=%h echo=%0d done=%0d total=%0d,",
                  $realtime, what, e.mark_word, e.word_echo, e.done_res, e.frame_total,
                  " got mark=%h echo=%0d done=%0d total=%0d",
                  rsp_mark_word, rsp_word_echo, rsp_done_res, rsp_frame_total);
   endfunction

   always @(posedge clock) begin
      mark_beat_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (marks_due.size() == 0) begin
               e = '{default: '0};
               fail_beat("no beat due", e);
            end else begin
               e = marks_due.pop_front();
               if (rsp_mark_word !== e.mark_word || rsp_word_echo !== e.word_echo ||
                   rsp_done_res !== e.done_res || rsp_frame_total !== e.frame_total)
                  fail_beat("field", e);
            end
         end
         if (start && !busy) predict_beat();
         if (psel && penable && pwrite && pready) csr_update(paddr >> 3, pwdata);
      end
      pending = marks_due.size();
   end
endmodule

// ===== test/contact_run_cleanup_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contact_run_cleanup_tb
// Drives frame loads and mark reads into the contact run cleanup block in
// random bursts, rewrites its registers between sequences across their
// extremes, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module contact_run_cleanup_tb;
   import cru_tb_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       start = 0;
   logic                       busy;
   logic                       req_cmd = 0;
   logic signed [15:0]         req_pos_x = 0;
   logic signed [15:0]         req_pos_y = 0;
   logic signed [15:0]         req_pos_z = 0;
   logic [15:0]                req_speed = 0;
   logic                       req_last = 0;
   logic [cru_pkg::WIDX_W-1:0] req_word_index = 0;
   logic                       rsp_valid;
   logic [63:0]                rsp_mark_word;
   logic [cru_pkg::WIDX_W-1:0] rsp_word_echo;
   logic                       rsp_done_res;
   logic [cru_pkg::CNT_W-1:0]  rsp_frame_total;
   logic                       psel = 0;
   logic                       penable = 0;
   logic                       pwrite = 0;
   logic [5:0]                 paddr = 0;
   logic [63:0]                pwdata = 0;
   logic [63:0]                prdata;
   logic                       pready;
   int                         mismatches;
   int                         pending;

   int loads = 0, reads = 0, sequences = 0, settings = 0;
   int burst_left = 0, idle_max = 4;
   int ht = 0, st = 0, stall = 0;
   int bx = 0, by = 0, bz = 0;

   always #2 clock = ~clock;

   contact_run_cleanup uut (.*);

   contact_run_cleanup_check chk (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) stall <= 0;
      else stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
         $display("contact_run_cleanup_tb: FAIL");
         $finish;
      end
   end

   task automatic send_beat(bit cmd, int x, int y, int z, int sp, bit lst, int widx);
      int g;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         g = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
         if (g > 0) begin
            start = 0;
            repeat (g) @(negedge clock);
         end
      end
      req_cmd = cmd; req_pos_x = x; req_pos_y = y; req_pos_z = z;
      req_speed = sp; req_last = lst; req_word_index = widx;
      start = 1;
      while (busy) @(negedge clock);
      @(posedge clock);
      burst_left--;
      if (cmd == CMD_READ) reads++;
      else loads++;
   endtask

   task automatic go_idle();
      @(negedge clock);
      start = 0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic csr_write(csr_reg_type idx, longint unsigned v);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = 6'(int'(idx) * 8); pwdata = v;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      if (idx == REG_HEIGHT_LIM) ht = $signed(v[15:0]);
      if (idx == REG_SPEED_LIM) st = v[15:0];
   endtask

   function automatic int pick(int lo, int hi, int mlo, int mhi);
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return $urandom_range(mlo, mhi);
   endfunction

   task automatic random_setting();
      longint unsigned d;
      go_idle();
      csr_write(REG_HEIGHT_LIM, longint'(pick(-32768, 32767, -200, 300)) & 16'hFFFF);
      csr_write(REG_SPEED_LIM, pick(0, 65535, 1, 4000));
      csr_write(REG_MIN_RUN, pick(1, 1024, 1, 6));
      csr_write(REG_TRIM, pick(0, 512, 0, 4));
      csr_write(REG_FILL_EN, $urandom_range(0, 3) != 0);
      csr_write(REG_SHORT_GAP, pick(0, 1024, 0, 8));
      csr_write(REG_POS_GAP, pick(0, 1024, 0, 14));
      d = {$urandom, $urandom} >> $urandom_range(30, 63);
      if ($urandom_range(0, 7) == 0) d = 34'h3_FFFF_FFFF;
      csr_write(REG_GAP_DIST, d);
      settings++;
   endtask

   task automatic load_frame(bit want, bit lst);
      int y, sp;
      if (want && ht > -32768 && st > 0) begin
         y  = $urandom_range(0, ht + 32767) - 32768;
         sp = $urandom_range(0, st - 1);
      end else if ($urandom_range(0, 15) == 0) begin
         y  = $urandom_range(0, 65535) - 32768;
         sp = $urandom_range(0, 65535);
      end else if ($urandom_range(0, 1) == 0) begin
         y  = ht + $urandom_range(0, 32767 - ht);
         sp = $urandom_range(0, 65535);
      end else begin
         y  = $urandom_range(0, 65535) - 32768;
         sp = st + $urandom_range(0, 65535 - st);
      end
      if ($urandom_range(0, 4) == 0) begin
         bx = $urandom_range(0, 65535) - 32768;
         bz = $urandom_range(0, 65535) - 32768;
      end else begin
         bx = 16'(bx + $urandom_range(0, 14) - 7);
         bz = 16'(bz + $urandom_range(0, 14) - 7);
      end
      send_beat(CMD_LOAD, bx, y, bz, sp, lst, $urandom_range(0, 15));
   endtask

   task automatic run_sequence(int len);
      int i, left;
      bit want;
      want = $urandom_range(0, 1);
      left = 0;
      for (i = 0; i < len; i++) begin
         if (left == 0) begin
            want = !want;
            left = want ? $urandom_range(1, 12) : $urandom_range(1, 10);
         end
         left--;
         if ($urandom_range(0, 11) == 0)
            send_beat(CMD_READ, 0, 0, 0, 0, 0, $urandom_range(0, i / 64));
         load_frame(want, i == len - 1);
      end
      repeat ($urandom_range(1, 3))
         send_beat(CMD_READ, 0, 0, 0, 0, 0, $urandom_range(0, 15));
      sequences++;
   endtask

   initial begin
      int s, n;
      bit long_done;
      long_done = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reads before any load, field extremes, a two frame and a single frame sequence
      send_beat(CMD_READ, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_READ, 0, 0, 0, 0, 0, 15);
      send_beat(CMD_LOAD, -32768, -32768, -32768, 0, 0, 15);
      send_beat(CMD_LOAD, 32767, 32767, 32767, 65535, 1, 0);
      send_beat(CMD_READ, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_LOAD, 0, -1, 0, 0, 1, 0);

      go_idle();
      csr_write(REG_HEIGHT_LIM, 0);
      csr_write(REG_SPEED_LIM, 100);
      csr_write(REG_MIN_RUN, 2);
      csr_write(REG_TRIM, 1);
      csr_write(REG_FILL_EN, 1);
      csr_write(REG_SHORT_GAP, 3);
      csr_write(REG_POS_GAP, 5);
      csr_write(REG_GAP_DIST, 100);
      settings++;
      // isolated frame, trimmed long run, short and position gaps, trailing gap
      for (s = 0; s < 19; s++)
         send_beat(CMD_LOAD, 5, (s inside {1, 3, 4, 5, 6, 7, 10, 11, 12, 16, 17}) ? -5 : 5,
                   s, 7, s == 18, 0);
      send_beat(CMD_READ, 0, 0, 0, 0, 0, 0);

      while (loads + reads < 1300) begin
         random_setting();
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         for (s = $urandom_range(1, 3); s > 0; s--) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 60);
            if (!long_done && settings >= 4) begin
               n = 1030;
               long_done = 1;
            end
            run_sequence(n);
         end
      end

      @(negedge clock);
      start = 0;
      n = 0;
      while (pending != 0 && n < STALL_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (100) @(negedge clock);
      $display("ran %0d frame loads and %0d mark reads in %0d sequences", loads, reads,
               sequences);
      $display("over %0d register settings", settings);
      if (mismatches == 0 && pending == 0) begin
         $display("contact_run_cleanup_tb: PASS");
      end else begin
         $display("contact_run_cleanup_tb: FAIL");
      end
      $finish;
   end
endmodule
